// ===== rtl/sus_pkg.sv =====
// Package with the constants, codes and controller interface types of the sorted address set.
`timescale 1ns / 1ps
package sus_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = 32;
  localparam int IN_IDX_W = 6;
  localparam int OUT_CNT_W = 7;
  localparam int CMP_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_READ_OK   = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  localparam logic [2:0] RA_INDEX  = 3'd0;
  localparam logic [2:0] RA_ZERO   = 3'd1;
  localparam logic [2:0] RA_PTR_P1 = 3'd2;
  localparam logic [2:0] RA_CNT_M1 = 3'd3;
  localparam logic [2:0] RA_PTR_M2 = 3'd4;

  typedef struct packed {
    logic       load;
    logic       ptr_inc;
    logic       ptr_from_count;
    logic       ptr_dec;
    logic       pos_from_ptr;
    logic       pos_from_ptr_p1;
    logic       re;
    logic [2:0] ra_src;
    logic       we_shift;
    logic       we_place;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       set_status;
    logic [2:0] status;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic             is_lt;
    logic             is_eq;
    logic             scan_last;
    logic             shift_last;
    logic             empty;
    logic             full;
    logic             idx_in_range;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

// ===== rtl/sus_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module sus_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sus_dp.sv =====
// Datapath of the sorted address set: entry memory, pointers, count and result registers.
`timescale 1ns / 1ps
module sus_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sus_pkg::cmd_t                 cmd,
  output sus_pkg::sts_t                 sts,
  input  logic [sus_pkg::ADDR_W-1:0]    in_addr,
  input  logic [sus_pkg::IN_IDX_W-1:0]  in_index,
  output logic [2:0]                    out_status,
  output logic [sus_pkg::ADDR_W-1:0]    out_read_addr,
  output logic [sus_pkg::OUT_CNT_W-1:0] out_count
);
  import sus_pkg::*;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [ADDR_W-1:0]   addr_r;
  logic [IN_IDX_W-1:0] idx_r;
  logic [2:0]          res_status_r;
  logic [2:0]          out_status_r;
  logic [ADDR_W-1:0]   out_read_addr_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic [ADDR_W-1:0]   wdata;
  logic [ADDR_W-1:0]   rdata;
  logic [CNT_W-1:0]    ptr_p1;
  logic [CNT_W-1:0]    ptr_m1;
  logic [CNT_W-1:0]    ptr_m2;
  logic [CNT_W-1:0]    cnt_m1;

  assign ptr_p1 = ptr_r + CNT_W'(1);
  assign ptr_m1 = ptr_r - CNT_W'(1);
  assign ptr_m2 = ptr_r - CNT_W'(2);
  assign cnt_m1 = count_r - CNT_W'(1);

  always_comb begin
    unique case (cmd.ra_src)
      RA_INDEX:  raddr = IDX_W'(in_index);
      RA_ZERO:   raddr = '0;
      RA_PTR_P1: raddr = IDX_W'(ptr_p1);
      RA_CNT_M1: raddr = IDX_W'(cnt_m1);
      RA_PTR_M2: raddr = IDX_W'(ptr_m2);
      default:   raddr = '0;
    endcase
  end

  assign waddr = cmd.we_place ? IDX_W'(pos_r) : IDX_W'(ptr_r);
  assign wdata = cmd.we_place ? addr_r : rdata;

  sus_ram #(
    .Width(ADDR_W),
    .Depth(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.we_shift | cmd.we_place),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_p1;
    end else if (cmd.ptr_from_count) begin
      ptr_nxt = count_r;
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_m1;
    end
    pos_nxt = pos_r;
    if (cmd.load) begin
      pos_nxt = '0;
    end else if (cmd.pos_from_ptr) begin
      pos_nxt = ptr_r;
    end else if (cmd.pos_from_ptr_p1) begin
      pos_nxt = ptr_p1;
    end
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    pos_r <= pos_nxt;
    if (cmd.load) begin
      addr_r <= in_addr;
      idx_r  <= in_index;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status_r    <= res_status_r;
      out_read_addr_r <= (res_status_r == ST_READ_OK) ? rdata : '0;
      out_count_r     <= OUT_CNT_W'(count_r);
    end
  end

  assign sts.is_lt        = rdata < addr_r;
  assign sts.is_eq        = rdata == addr_r;
  assign sts.scan_last    = ptr_p1 == count_r;
  assign sts.shift_last   = ptr_m1 == pos_r;
  assign sts.empty        = count_r == '0;
  assign sts.full         = count_r == CNT_W'(CAPACITY);
  assign sts.idx_in_range = CMP_W'(idx_r) < CMP_W'(count_r);
  assign sts.count        = count_r;

  assign out_status    = out_status_r;
  assign out_read_addr = out_read_addr_r;
  assign out_count     = out_count_r;

endmodule

// ===== rtl/sus_ctrl.sv =====
// Controller state machine of the sorted address set with the result valid flag.
`timescale 1ns / 1ps
module sus_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_req_type,
  output logic          out_valid,
  input  logic          out_ready,
  input  sus_pkg::sts_t sts,
  output sus_pkg::cmd_t cmd
);
  import sus_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.ra_src = RA_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_req_type)
            REQ_INSERT: begin
              if (sts.empty) begin
                state_nxt = S_PLACE;
              end else begin
                cmd.re     = 1'b1;
                cmd.ra_src = RA_ZERO;
                state_nxt  = S_SCAN;
              end
            end
            REQ_READ: begin
              cmd.re     = 1'b1;
              cmd.ra_src = RA_INDEX;
              state_nxt  = S_READ;
            end
            REQ_CLEAR: begin
              cmd.cnt_clr    = 1'b1;
              cmd.set_status = 1'b1;
              cmd.status     = ST_CLEARED;
              state_nxt      = S_DONE;
            end
            default: begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.set_status = 1'b1;
        cmd.status     = sts.idx_in_range ? ST_READ_OK : ST_RANGE;
        state_nxt      = S_DONE;
      end
      S_SCAN: begin
        priority if (sts.is_eq) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DUPLICATE;
          state_nxt      = S_DONE;
        end else if (sts.is_lt && !sts.scan_last) begin
          cmd.ptr_inc = 1'b1;
          cmd.re      = 1'b1;
          cmd.ra_src  = RA_PTR_P1;
        end else if (sts.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_DONE;
        end else if (sts.is_lt) begin
          cmd.pos_from_ptr_p1 = 1'b1;
          state_nxt           = S_PLACE;
        end else begin
          cmd.pos_from_ptr   = 1'b1;
          cmd.ptr_from_count = 1'b1;
          cmd.re             = 1'b1;
          cmd.ra_src         = RA_CNT_M1;
          state_nxt          = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.we_shift = 1'b1;
        cmd.ptr_dec  = 1'b1;
        if (sts.shift_last) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.re     = 1'b1;
          cmd.ra_src = RA_PTR_M2;
        end
      end
      S_PLACE: begin
        cmd.we_place   = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_INSERTED;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/sorted_unique_set_insert.sv =====
// Top level of the sorted set of unique addresses with insert, read and clear requests.
// A clear or an unused code goes straight to the result; a read passes through the read state.
// A duplicate or full insert ends at the scan; other inserts scan and shift as needed, then place.
// An insert scans one entry per cycle and shifts one entry per cycle through the single RAM.
// A new request is taken only in the idle state, after the previous result has entered the output register.
// Reset empties the set by zeroing the count; the entry memory itself is not cleared.
`timescale 1ns / 1ps
module sorted_unique_set_insert (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [sus_pkg::ADDR_W-1:0]    in_addr,
  input  logic [sus_pkg::IN_IDX_W-1:0]  in_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [sus_pkg::ADDR_W-1:0]    out_read_addr,
  output logic [sus_pkg::OUT_CNT_W-1:0] out_count
);
  import sus_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sus_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sus_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_addr      (in_addr),
    .in_index     (in_index),
    .out_status   (out_status),
    .out_read_addr(out_read_addr),
    .out_count    (out_count)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.we_shift || cmd.we_place) |-> !in_ready)
    else $error("Memory written while the block is idle.");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_CLEARED) |-> out_count == '0)
    else $error("Clear result reports a nonzero count.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_count == OUT_CNT_W'(CAPACITY))
    else $error("Full result reports a count below capacity.");
`endif

endmodule

// ===== tb/tb_sorted_unique_set_insert.sv =====
// Self-checking testbench for the sorted set of unique addresses.
`timescale 1ns / 1ps
module tb_sorted_unique_set_insert;
  import sus_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_AFTER = 560;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_W-1:0]    read_addr;
    logic [OUT_CNT_W-1:0] count;
  } set_reply_t;

  class set_scoreboard;
    logic [ADDR_W-1:0] held [CAPACITY];
    int unsigned held_count;
    set_reply_t pending_replies[$];
    int unsigned mismatches;

    function void note_request(logic [1:0] req, logic [ADDR_W-1:0] a,
                               logic [IN_IDX_W-1:0] idx);
      set_reply_t reply;
      int unsigned pos;
      reply.status = ST_RANGE;
      reply.read_addr = '0;
      case (req)
        REQ_INSERT: begin
          pos = 0;
          while (pos < held_count && held[pos] < a) pos++;
          if (pos < held_count && held[pos] == a) begin
            reply.status = ST_DUPLICATE;
          end else if (held_count >= CAPACITY) begin
            reply.status = ST_FULL;
          end else begin
            for (int k = held_count; k > pos; k--) held[k] = held[k-1];
            held[pos] = a;
            held_count++;
            reply.status = ST_INSERTED;
          end
        end
        REQ_READ: begin
          if (idx < held_count) begin
            reply.read_addr = held[idx];
            reply.status = ST_READ_OK;
          end
        end
        REQ_CLEAR: begin
          held_count = 0;
          reply.status = ST_CLEARED;
        end
        default: reply.status = ST_RANGE;
      endcase
      reply.count = held_count[OUT_CNT_W-1:0];
      pending_replies.push_back(reply);
    endfunction

    function void check_result(logic [2:0] status, logic [ADDR_W-1:0] read_addr,
                               logic [OUT_CNT_W-1:0] count);
      set_reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: status %0d addr %h count %0d",
                   status, read_addr, count);
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status || read_addr !== want.read_addr ||
          count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected status %0d addr %h count %0d, got %0d %h %0d",
                   want.status, want.read_addr, want.count, status, read_addr, count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_req_type;
  logic [ADDR_W-1:0] in_addr;
  logic [IN_IDX_W-1:0] in_index;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_status;
  logic [ADDR_W-1:0] out_read_addr;
  logic [OUT_CNT_W-1:0] out_count;

  set_scoreboard sb;
  bit quiet;
  int unsigned sent;
  int unsigned send_budget;
  int unsigned cycles = 0;

  sorted_unique_set_insert i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_addr       (in_addr),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_read_addr (out_read_addr),
    .out_count     (out_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("tb_sorted_unique_set_insert NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_read_addr, out_count);
  end

  initial begin
    int unsigned stall_budget;
    out_ready <= 1'b0;
    stall_budget = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && stall_budget == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        stall_budget = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b1;
        if (stall_budget > 0) stall_budget--;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [ADDR_W-1:0] a,
                              input logic [IN_IDX_W-1:0] idx);
    if (!quiet && send_budget == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      send_budget = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 5);
    end else if (send_budget > 0) begin
      send_budget--;
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_addr <= a;
    in_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, a, idx);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic random_request(input bit filling);
    int unsigned roll;
    int unsigned pick;
    logic [1:0] req;
    logic [ADDR_W-1:0] a;
    logic [IN_IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    a = $urandom;
    idx = IN_IDX_W'($urandom_range(0, 63));
    if (filling) begin
      req = (roll < 85) ? REQ_INSERT : REQ_READ;
    end else begin
      if (roll < 45) req = REQ_INSERT;
      else if (roll < 80) req = REQ_READ;
      else if (roll < 90) req = REQ_CLEAR;
      else req = REQ_UNUSED;
    end
    if (req == REQ_INSERT) begin
      pick = $urandom_range(0, 9);
      if (pick < 3 && sb.held_count > 0)
        a = sb.held[$urandom_range(0, sb.held_count - 1)];
      else if (pick == 3)
        a = $urandom_range(0, 15);
      else if (pick == 4)
        a = 32'hFFFF_FFFF - $urandom_range(0, 15);
    end else if (req == REQ_READ && sb.held_count > 0 && $urandom_range(0, 9) < 7) begin
      idx = IN_IDX_W'($urandom_range(0, sb.held_count - 1));
    end
    send_request(req, a, idx);
    sent++;
  endtask

  initial begin
    int unsigned seg_len;
    bit paused;
    sb = new();
    quiet = 1'b0;
    paused = 1'b0;
    sent = 0;
    send_budget = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_INSERT;
    in_addr <= '0;
    in_index <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_READ, 32'hFFFF_FFFF, 6'd0);
    send_request(REQ_INSERT, 32'h8000_0000, 6'd63);
    send_request(REQ_INSERT, 32'h0000_0000, 6'd0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 6'd0);
    send_request(REQ_INSERT, 32'h0000_0000, 6'd0);
    send_request(REQ_INSERT, 32'h0000_0001, 6'd0);
    send_request(REQ_INSERT, 32'hFFFF_FFFE, 6'd0);
    send_request(REQ_READ, 32'h0000_0000, 6'd0);
    send_request(REQ_READ, 32'hFFFF_FFFF, 6'd1);
    send_request(REQ_READ, 32'h0000_0000, 6'd2);
    send_request(REQ_READ, 32'h0000_0000, 6'd4);
    send_request(REQ_READ, 32'h0000_0000, 6'd5);
    send_request(REQ_READ, 32'h0000_0000, 6'd63);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_UNUSED, 32'h0000_0000, 6'd0);
    send_request(REQ_CLEAR, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_READ, 32'h0000_0000, 6'd0);
    send_request(REQ_CLEAR, 32'h0000_0000, 6'd0);
    send_request(REQ_INSERT, 32'h1234_5678, 6'd63);
    send_request(REQ_READ, 32'hFFFF_FFFF, 6'd0);
    drain_results();

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        while (sb.held_count < CAPACITY && sent < RANDOM_ITEMS) random_request(1'b1);
        repeat (12) random_request(1'b1);
      end else begin
        seg_len = $urandom_range(15, 40);
        repeat (seg_len) random_request(1'b0);
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end
      if (sent >= QUIET_AFTER) quiet = 1'b1;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("tb_sorted_unique_set_insert OK");
    end else begin
      $display("tb_sorted_unique_set_insert NOT OK");
    end
    $finish;
  end

endmodule
